### hdl/shannon_fano_encoder_defines.svh
// ----------------------------------------------------------------------------
// shannon_fano_encoder_defines.svh
// Assertion macros used by the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef SHANNON_FANO_ENCODER_DEFINES_SVH
`define SHANNON_FANO_ENCODER_DEFINES_SVH

// expression holds at every clock edge out of reset
`define SFE_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// Constants, opcodes and status codes of the Shannon-Fano encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sfe_pkg;

    localparam int MAX_CODE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF    = 24;
    localparam int ALPHABET_DEF      = 256;

    localparam int SYM_W   = 8;
    localparam int DEPTH   = 256;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int PLEN_W  = 8;
    localparam int ENTRY_W = 24;

    typedef enum logic [2:0] {
        OP_COUNT = 3'd0,
        OP_BUILD = 3'd1,
        OP_ENC   = 3'd2,
        OP_FLUSH = 3'd3,
        OP_READ  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_TOOLONG = 2'd2
    } t_status;

endpackage

`default_nettype wire

### hdl/shannon_fano_encoder.sv
// ----------------------------------------------------------------------------
// shannon_fano_encoder
// Static Shannon-Fano byte encoder with histogram, code build and bit packer.
// ----------------------------------------------------------------------------
// Requests enter on i_valid/o_ready with an opcode, a symbol and an entry
// index; results leave on o_valid/i_ready through one output register.
// o_ready is high only while the sequencer is idle, so one request is worked
// at a time.
// Count: no result. Flush: one result. Read entry: one result.
// Encode: reads the code and shifts out its bits (up to 32) one at a time,
// one result per completed byte or one empty result.
// Build: a selection sort scans all ALPHABET histogram bins once per used
// symbol and once more; with two or more used symbols each split group is
// then summed, walked through the subtract/compare unit and updated one entry
// at a time, then a check pass and, unless a code is too long, a write pass
// follow; one status result ends it.
// Reset clears the histogram and code valid bits, the stack pointer, the
// packer and the output register; no clearing pass is needed.
// A stalled receiver holds the output register; the sequencer waits in the
// state that produces the next result until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "shannon_fano_encoder_defines.svh"

module shannon_fano_encoder
    import sfe_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int ALPHABET      = ALPHABET_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [2:0]          i_opcode,
    input  wire logic [SYM_W-1:0]    i_symbol,
    input  wire logic [SYM_W-1:0]    i_entry_index,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [7:0]               o_out_byte,
    output logic                     o_byte_valid,
    output logic                     o_last,
    output logic [1:0]               o_status,
    output logic [SYM_W-1:0]         o_entry_symbol,
    output logic [ENTRY_W-1:0]       o_entry_count,
    output logic                     o_entry_valid
);

    localparam int CW        = COUNT_BITS;
    localparam int TW        = COUNT_BITS + SYM_W;
    localparam int DW        = TW + 2;
    localparam int LEN_LIMIT = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;

    typedef enum logic [28:0] {
        S_IDLE    = 29'b1 << 0,
        S_CNT_RD  = 29'b1 << 1,
        S_CNT_WR  = 29'b1 << 2,
        S_SORT    = 29'b1 << 3,
        S_CLR     = 29'b1 << 4,
        S_PUSH0   = 29'b1 << 5,
        S_POP     = 29'b1 << 6,
        S_POP_LD  = 29'b1 << 7,
        S_TOT     = 29'b1 << 8,
        S_WALK0   = 29'b1 << 9,
        S_WALK1   = 29'b1 << 10,
        S_WALK    = 29'b1 << 11,
        S_WALK2   = 29'b1 << 12,
        S_AS_RD   = 29'b1 << 13,
        S_AS_WR   = 29'b1 << 14,
        S_PUSHL   = 29'b1 << 15,
        S_PUSHR   = 29'b1 << 16,
        S_CHK_RD  = 29'b1 << 17,
        S_CHK_EV  = 29'b1 << 18,
        S_WR_RD   = 29'b1 << 19,
        S_WR_WR   = 29'b1 << 20,
        S_BST     = 29'b1 << 21,
        S_ENC_RD  = 29'b1 << 22,
        S_ENC_LD  = 29'b1 << 23,
        S_ENC_BIT = 29'b1 << 24,
        S_FLUSH   = 29'b1 << 25,
        S_RB_RD   = 29'b1 << 26,
        S_RB_H    = 29'b1 << 27,
        S_RB_OUT  = 29'b1 << 28
    } t_state;

    // memories
    logic [CW-1:0]     hist [DEPTH];
    logic [SYM_W-1:0]  ssym [DEPTH];
    logic [CW-1:0]     scnt [DEPTH];
    logic [PLEN_W-1:0] plen [DEPTH];
    logic [CODE_W-1:0] pcode [DEPTH];
    logic [15:0]       stk [DEPTH];
    logic [CODE_W-1:0] cstore [DEPTH];
    logic [LEN_W-1:0]  clen [DEPTH];

    logic [DEPTH-1:0]  r_hv;
    logic [DEPTH-1:0]  r_cv;

    logic [CW-1:0]     r_hist_q;
    logic              r_hv_q;
    logic [SYM_W-1:0]  r_ss_q;
    logic [CW-1:0]     r_sc_q;
    logic [PLEN_W-1:0] r_pl_q;
    logic [CODE_W-1:0] r_pc_q;
    logic [15:0]       r_st_q;
    logic [CODE_W-1:0] r_cs_q;
    logic [LEN_W-1:0]  r_cl_q;
    logic              r_cv_q;

    t_state            r_state, n_state;
    logic [SYM_W-1:0]  r_sym, n_sym;
    logic [SYM_W-1:0]  r_idx, n_idx;
    logic [8:0]        r_s, n_s;
    logic              r_dv, n_dv;
    logic [SYM_W-1:0]  r_sd, n_sd;
    logic              r_found, n_found;
    logic              r_first, n_first;
    logic [CW-1:0]     r_best_cnt, n_best_cnt;
    logic [SYM_W-1:0]  r_best_sym, n_best_sym;
    logic [CW-1:0]     r_prev_cnt, n_prev_cnt;
    logic [SYM_W-1:0]  r_prev_sym, n_prev_sym;
    logic [8:0]        r_pos, n_pos;
    logic [8:0]        r_used, n_used;
    logic [8:0]        r_i, n_i;
    logic [SYM_W-1:0]  r_gfirst, n_gfirst;
    logic [SYM_W-1:0]  r_last, n_last;
    logic [SYM_W-1:0]  r_ptr, n_ptr;
    logic [TW-1:0]     r_total, n_total;
    logic [DW-1:0]     r_dif, n_dif;
    logic [8:0]        r_sp, n_sp;
    logic              r_too_long, n_too_long;
    logic [1:0]        r_status, n_status;
    logic [LEN_W-1:0]  r_n, n_n;
    logic [LEN_W-1:0]  r_bi, n_bi;
    logic [CODE_W-1:0] r_c, n_c;
    logic              r_k, n_k;
    logic [7:0]        r_acc, n_acc;
    logic [2:0]        r_bp, n_bp;

    logic              r_ovalid;
    logic [7:0]        r_obyte;
    logic              r_obv, r_olast, r_oev;
    logic [1:0]        r_ostat;
    logic [SYM_W-1:0]  r_oes;
    logic [ENTRY_W-1:0] r_oec;

    // memory controls
    logic              h_we;
    logic [CW-1:0]     h_wd;
    logic [SYM_W-1:0]  h_ra;
    logic              s_we;
    logic [SYM_W-1:0]  ss_ra, sc_ra;
    logic              p_we;
    logic [PLEN_W-1:0] p_wl;
    logic [CODE_W-1:0] p_wc;
    logic              st_we;
    logic [SYM_W-1:0]  st_wa;
    logic [15:0]       st_wd;
    logic              c_we;
    logic [SYM_W-1:0]  c_wa;
    logic [LEN_W-1:0]  c_wl;
    logic [CODE_W-1:0] c_wc;
    logic              cv_clr;

    // result push
    logic              p_push;
    logic [7:0]        p_byte;
    logic              p_bv, p_last, p_ev;
    logic [1:0]        p_stat;
    logic [SYM_W-1:0]  p_es;
    logic [ENTRY_W-1:0] p_ec;

    logic              out_free;
    logic              accept;
    logic [CW-1:0]     cur_cnt;
    logic              qual, better;
    logic [TW-1:0]     half;
    logic [DW-1:0]     dif_b, abs_a, abs_b;
    logic [7:0]        acc_nx;
    logic [31:0]       cnt32;
    logic              do_push;

    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;

    assign cur_cnt = r_hv_q ? r_hist_q : '0;
    assign qual    = (cur_cnt != '0) && (r_first || (cur_cnt < r_prev_cnt) ||
                     ((cur_cnt == r_prev_cnt) && (r_sd < r_prev_sym)));
    assign better  = !r_found || (cur_cnt > r_best_cnt) ||
                     ((cur_cnt == r_best_cnt) && (r_sd > r_best_sym));

    assign half  = r_total >> 1;
    assign dif_b = r_dif - DW'(r_sc_q);
    assign abs_a = r_dif[DW-1] ? (~r_dif + DW'(1)) : r_dif;
    assign abs_b = dif_b[DW-1] ? (~dif_b + DW'(1)) : dif_b;
    assign acc_nx = r_acc | (8'(r_c[0]) << r_bp);
    assign cnt32 = 32'(cur_cnt);

    always_comb begin
        n_state = r_state;  n_sym = r_sym;  n_idx = r_idx;
        n_s = r_s;  n_dv = r_dv;  n_sd = r_sd;  n_found = r_found;  n_first = r_first;
        n_best_cnt = r_best_cnt;  n_best_sym = r_best_sym;
        n_prev_cnt = r_prev_cnt;  n_prev_sym = r_prev_sym;
        n_pos = r_pos;  n_used = r_used;  n_i = r_i;
        n_gfirst = r_gfirst;  n_last = r_last;  n_ptr = r_ptr;
        n_total = r_total;  n_dif = r_dif;  n_sp = r_sp;
        n_too_long = r_too_long;  n_status = r_status;
        n_n = r_n;  n_bi = r_bi;  n_c = r_c;  n_k = r_k;
        n_acc = r_acc;  n_bp = r_bp;

        h_we = 1'b0;  h_wd = cur_cnt + CW'(1);  h_ra = r_sym;
        s_we = 1'b0;  ss_ra = r_i[7:0];  sc_ra = r_i[7:0];
        p_we = 1'b0;  p_wl = '0;  p_wc = '0;
        st_we = 1'b0;  st_wa = r_sp[7:0];  st_wd = '0;
        c_we = 1'b0;  c_wa = r_ss_q;  c_wl = r_pl_q[LEN_W-1:0];  c_wc = r_pc_q;
        cv_clr = 1'b0;
        do_push = 1'b0;

        p_push = 1'b0;  p_byte = '0;  p_bv = 1'b0;  p_last = 1'b0;
        p_stat = ST_OK;  p_es = '0;  p_ec = '0;  p_ev = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_sym = i_symbol;
                    n_idx = i_entry_index;
                    case (i_opcode)
                        OP_COUNT: n_state = S_CNT_RD;
                        OP_BUILD: begin
                            cv_clr  = 1'b1;
                            n_s     = '0;
                            n_dv    = 1'b0;
                            n_found = 1'b0;
                            n_first = 1'b1;
                            n_pos   = '0;
                            n_state = S_SORT;
                        end
                        OP_ENC:   n_state = S_ENC_RD;
                        OP_FLUSH: n_state = S_FLUSH;
                        OP_READ:  n_state = S_RB_RD;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_CNT_RD: n_state = S_CNT_WR;
            S_CNT_WR: begin
                h_we    = ({1'b0, r_sym} < 9'(ALPHABET)) && (cur_cnt != {CW{1'b1}});
                n_state = S_IDLE;
            end
            S_SORT: begin
                h_ra = r_s[7:0];
                if (r_s < 9'(ALPHABET)) begin
                    n_dv = 1'b1;
                    n_sd = r_s[7:0];
                    n_s  = r_s + 9'd1;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv && qual && better) begin
                    n_found    = 1'b1;
                    n_best_cnt = cur_cnt;
                    n_best_sym = r_sd;
                end
                if ((r_s == 9'(ALPHABET)) && !r_dv) begin
                    if (r_found) begin
                        s_we       = 1'b1;
                        n_pos      = r_pos + 9'd1;
                        n_prev_cnt = r_best_cnt;
                        n_prev_sym = r_best_sym;
                        n_first    = 1'b0;
                        n_found    = 1'b0;
                        n_s        = '0;
                    end else begin
                        n_used = r_pos;
                        if (r_pos == 9'd0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_BST;
                        end else if (r_pos == 9'd1) begin
                            c_we     = 1'b1;
                            c_wa     = r_prev_sym;
                            c_wl     = LEN_W'(1);
                            c_wc     = '0;
                            n_status = ST_OK;
                            n_state  = S_BST;
                        end else begin
                            n_i     = '0;
                            n_state = S_CLR;
                        end
                    end
                end
            end
            S_CLR: begin
                p_we = 1'b1;
                if (r_i == r_used - 9'd1) begin
                    n_state = S_PUSH0;
                end else begin
                    n_i = r_i + 9'd1;
                end
            end
            S_PUSH0: begin
                st_we   = 1'b1;
                st_wa   = '0;
                st_wd   = {8'd0, 8'(r_used - 9'd1)};
                n_sp    = 9'd1;
                n_state = S_POP;
            end
            S_POP: begin
                n_sp    = r_sp - 9'd1;
                n_state = S_POP_LD;
            end
            S_POP_LD: begin
                n_gfirst = r_st_q[15:8];
                n_last   = r_st_q[7:0];
                n_total  = '0;
                n_i      = {1'b0, r_st_q[15:8]};
                n_dv     = 1'b0;
                n_state  = S_TOT;
            end
            S_TOT: begin
                if (r_i <= {1'b0, r_last}) begin
                    n_dv = 1'b1;
                    n_i  = r_i + 9'd1;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    n_total = r_total + TW'(r_sc_q);
                end
                if ((r_i > {1'b0, r_last}) && !r_dv) begin
                    n_state = S_WALK0;
                end
            end
            S_WALK0: begin
                sc_ra   = r_gfirst;
                n_state = S_WALK1;
            end
            S_WALK1: begin
                n_dif   = DW'(half) - DW'(r_sc_q);
                n_ptr   = r_gfirst;
                n_state = S_WALK;
            end
            S_WALK: begin
                sc_ra = r_ptr + 8'd1;
                if (({1'b0, r_ptr} + 9'd1) < {1'b0, r_last}) begin
                    n_state = S_WALK2;
                end else begin
                    n_i     = {1'b0, r_gfirst};
                    n_state = S_AS_RD;
                end
            end
            S_WALK2: begin
                sc_ra = r_ptr + 8'd1;
                if (abs_a > abs_b) begin
                    n_ptr   = r_ptr + 8'd1;
                    n_dif   = dif_b;
                    n_state = S_WALK;
                end else begin
                    n_i     = {1'b0, r_gfirst};
                    n_state = S_AS_RD;
                end
            end
            S_AS_RD: n_state = S_AS_WR;
            S_AS_WR: begin
                p_we = 1'b1;
                p_wl = (r_pl_q < 8'd255) ? (r_pl_q + 8'd1) : r_pl_q;
                p_wc = r_pc_q;
                if ((r_pl_q < 8'(CODE_W)) && (r_i > {1'b0, r_ptr})) begin
                    p_wc = r_pc_q | (CODE_W'(1) << r_pl_q[4:0]);
                end
                if (r_i == {1'b0, r_last}) begin
                    n_state = S_PUSHL;
                end else begin
                    n_i     = r_i + 9'd1;
                    n_state = S_AS_RD;
                end
            end
            S_PUSHL: begin
                if ((r_ptr > r_gfirst) && (r_sp < 9'd256)) begin
                    st_we = 1'b1;
                    st_wd = {r_gfirst, r_ptr};
                    n_sp  = r_sp + 9'd1;
                end
                n_state = S_PUSHR;
            end
            S_PUSHR: begin
                do_push = ({1'b0, r_last} > ({1'b0, r_ptr} + 9'd1)) && (r_sp < 9'd256);
                if (do_push) begin
                    st_we = 1'b1;
                    st_wd = {r_ptr + 8'd1, r_last};
                    n_sp  = r_sp + 9'd1;
                end
                if ((r_sp == 9'd0) && !do_push) begin
                    n_i        = '0;
                    n_too_long = 1'b0;
                    n_state    = S_CHK_RD;
                end else begin
                    n_state = S_POP;
                end
            end
            S_CHK_RD: n_state = S_CHK_EV;
            S_CHK_EV: begin
                if ((r_pl_q > 8'(LEN_LIMIT)) || r_too_long) begin
                    n_too_long = 1'b1;
                end
                if (r_i == r_used - 9'd1) begin
                    n_i = '0;
                    if ((r_pl_q > 8'(LEN_LIMIT)) || r_too_long) begin
                        n_status = ST_TOOLONG;
                        n_state  = S_BST;
                    end else begin
                        n_state = S_WR_RD;
                    end
                end else begin
                    n_i     = r_i + 9'd1;
                    n_state = S_CHK_RD;
                end
            end
            S_WR_RD: n_state = S_WR_WR;
            S_WR_WR: begin
                c_we = 1'b1;
                if (r_i == r_used - 9'd1) begin
                    n_status = ST_OK;
                    n_state  = S_BST;
                end else begin
                    n_i     = r_i + 9'd1;
                    n_state = S_WR_RD;
                end
            end
            S_BST: begin
                if (out_free) begin
                    p_push  = 1'b1;
                    p_last  = 1'b1;
                    p_stat  = r_status;
                    n_state = S_IDLE;
                end
            end
            S_ENC_RD: n_state = S_ENC_LD;
            S_ENC_LD: begin
                n_n     = (({1'b0, r_sym} < 9'(ALPHABET)) && r_cv_q) ? r_cl_q : '0;
                n_c     = r_cs_q;
                n_bi    = '0;
                n_k     = 1'b0;
                n_state = S_ENC_BIT;
            end
            S_ENC_BIT: begin
                if (r_bi == r_n) begin
                    if (r_k) begin
                        n_state = S_IDLE;
                    end else if (out_free) begin
                        p_push  = 1'b1;
                        p_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if ((r_bp != 3'd7) || out_free) begin
                    n_c  = r_c >> 1;
                    n_bi = r_bi + LEN_W'(1);
                    n_bp = r_bp + 3'd1;
                    if (r_bp == 3'd7) begin
                        p_push = 1'b1;
                        p_byte = acc_nx;
                        p_bv   = 1'b1;
                        p_last = (r_n - r_bi - LEN_W'(1)) < LEN_W'(8);
                        n_acc  = '0;
                        n_k    = 1'b1;
                    end else begin
                        n_acc = acc_nx;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    p_push  = 1'b1;
                    p_last  = 1'b1;
                    p_bv    = (r_bp != 3'd0);
                    p_byte  = (r_bp != 3'd0) ? r_acc : 8'd0;
                    n_acc   = '0;
                    n_bp    = '0;
                    n_state = S_IDLE;
                end
            end
            S_RB_RD: begin
                ss_ra   = r_idx;
                n_state = S_RB_H;
            end
            S_RB_H: begin
                ss_ra   = r_idx;
                h_ra    = r_ss_q;
                n_state = S_RB_OUT;
            end
            S_RB_OUT: begin
                ss_ra = r_idx;
                h_ra  = r_ss_q;
                if (out_free) begin
                    p_push = 1'b1;
                    p_last = 1'b1;
                    if ({1'b0, r_idx} < r_used) begin
                        p_ev = 1'b1;
                        p_es = r_ss_q;
                        p_ec = (cnt32 > 32'(ENTRY_W'('1))) ? ENTRY_W'('1)
                                                           : cnt32[ENTRY_W-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_s        <= '0;
            r_dv       <= 1'b0;
            r_found    <= 1'b0;
            r_first    <= 1'b1;
            r_pos      <= '0;
            r_used     <= '0;
            r_i        <= '0;
            r_sp       <= '0;
            r_too_long <= 1'b0;
            r_status   <= ST_OK;
            r_n        <= '0;
            r_bi       <= '0;
            r_k        <= 1'b0;
            r_acc      <= '0;
            r_bp       <= '0;
        end else begin
            r_state    <= n_state;
            r_s        <= n_s;
            r_dv       <= n_dv;
            r_found    <= n_found;
            r_first    <= n_first;
            r_pos      <= n_pos;
            r_used     <= n_used;
            r_i        <= n_i;
            r_sp       <= n_sp;
            r_too_long <= n_too_long;
            r_status   <= n_status;
            r_n        <= n_n;
            r_bi       <= n_bi;
            r_k        <= n_k;
            r_acc      <= n_acc;
            r_bp       <= n_bp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_idx      <= n_idx;
        r_sd       <= n_sd;
        r_best_cnt <= n_best_cnt;
        r_best_sym <= n_best_sym;
        r_prev_cnt <= n_prev_cnt;
        r_prev_sym <= n_prev_sym;
        r_gfirst   <= n_gfirst;
        r_last     <= n_last;
        r_ptr      <= n_ptr;
        r_total    <= n_total;
        r_dif      <= n_dif;
        r_c        <= n_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= '0;
            r_cv <= '0;
        end else begin
            if (h_we) begin
                r_hv[r_sym] <= 1'b1;
            end
            if (cv_clr) begin
                r_cv <= '0;
            end else if (c_we) begin
                r_cv[c_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            hist[r_sym] <= h_wd;
        end
        r_hist_q <= hist[h_ra];
        r_hv_q   <= r_hv[h_ra];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            ssym[r_pos[7:0]] <= r_best_sym;
            scnt[r_pos[7:0]] <= r_best_cnt;
        end
        r_ss_q <= ssym[ss_ra];
        r_sc_q <= scnt[sc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            plen[r_i[7:0]]  <= p_wl;
            pcode[r_i[7:0]] <= p_wc;
        end
        r_pl_q <= plen[r_i[7:0]];
        r_pc_q <= pcode[r_i[7:0]];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            stk[st_wa] <= st_wd;
        end
        r_st_q <= stk[r_sp[7:0] - 8'd1];
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            cstore[c_wa] <= c_wc;
            clen[c_wa]   <= c_wl;
        end
        r_cs_q <= cstore[r_sym];
        r_cl_q <= clen[r_sym];
        r_cv_q <= r_cv[r_sym];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (p_push) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_push) begin
            r_obyte <= p_byte;
            r_obv   <= p_bv;
            r_olast <= p_last;
            r_ostat <= p_stat;
            r_oes   <= p_es;
            r_oec   <= p_ec;
            r_oev   <= p_ev;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_out_byte     = r_obyte;
    assign o_byte_valid   = r_obv;
    assign o_last         = r_olast;
    assign o_status       = r_ostat;
    assign o_entry_symbol = r_oes;
    assign o_entry_count  = r_oec;
    assign o_entry_valid  = r_oev;

    `SFE_ASSERT_ALWAYS(a_push_free, i_clk, i_rst_n, !p_push || !r_ovalid || i_ready, "result pushed into a full output register")
    `SFE_ASSERT_ALWAYS(a_walk_ptr, i_clk, i_rst_n, !(r_state == S_WALK || r_state == S_WALK2) || (r_ptr < r_last), "split pointer reached group end")
    `SFE_ASSERT_ALWAYS(a_used_max, i_clk, i_rst_n, r_used <= 9'(ALPHABET), "used symbol count exceeds alphabet")
    `SFE_ASSERT_NEXT(a_bp_hold, i_clk, i_rst_n, !(r_state == S_ENC_BIT || r_state == S_FLUSH), $stable(r_bp), "packer position moved outside encode or flush")

endmodule

`default_nettype wire
